// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
// Depends on nothing; each macro takes the clock and active-low reset explicitly.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check, disabled while reset is asserted.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Overlapping implication check, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication check, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/ssf_pkg.sv =====
// Types and constants of the servo sync packet framer.
// Used by the front end, the job queue and the byte sequencer; depends on nothing.
package ssf_pkg;

  // Packet kinds as carried on the input tuser field.
  typedef enum logic [1:0] {
    KIND_READ_POS    = 2'd0,
    KIND_WRITE_POS   = 2'd1,
    KIND_WRITE_SPEED = 2'd2,
    KIND_WRITE_BYTE  = 2'd3
  } kind_e;

  // Fixed bytes of the packet.
  localparam logic [7:0] SYNC_BYTE       = 8'hFF;
  localparam logic [7:0] BCAST_ID        = 8'hFE;
  localparam logic [7:0] INSTR_SYNC_RD   = 8'h82;
  localparam logic [7:0] INSTR_SYNC_WR   = 8'h83;
  localparam logic [7:0] REG_PRESENT_POS = 8'h38;
  localparam logic [7:0] REG_GOAL_POS    = 8'h2A;
  localparam logic [7:0] REG_SPEED       = 8'd46;

  // Byte positions within one job, in emission order.
  typedef logic [3:0] step_t;
  localparam step_t STEP_SYNC0 = 4'd0;
  localparam step_t STEP_SYNC1 = 4'd1;
  localparam step_t STEP_BCAST = 4'd2;
  localparam step_t STEP_LEN   = 4'd3;
  localparam step_t STEP_INST  = 4'd4;
  localparam step_t STEP_START = 4'd5;
  localparam step_t STEP_DLEN  = 4'd6;
  localparam step_t STEP_ID    = 4'd7;
  localparam step_t STEP_DATA0 = 4'd8;
  localparam step_t STEP_DATA1 = 4'd9;
  localparam step_t STEP_DATA2 = 4'd10;
  localparam step_t STEP_DATA3 = 4'd11;
  localparam step_t STEP_CSUM  = 4'd12;

  // Depth of the queue between the classifier and the sequencer.
  localparam int QUEUE_DEPTH = 4;

  // One classified servo entry, ready to be serialised.
  typedef struct packed {
    logic        first;      // entry opens the packet: emit the header
    logic        last;       // entry closes the packet: emit the checksum
    kind_e       kind;
    logic [7:0]  start_reg;
    logic [7:0]  len;
    logic [7:0]  id;
    logic [15:0] value;
  } ssf_job_t;

endpackage

// ===== design/ssf_front.sv =====
// Front end of the framer: accepts servo entries, tracks the packet in progress
// and turns each entry into a job for the queue. Depends on ssf_pkg.
module ssf_front
  import ssf_pkg::*;
#(
  parameter int MaxServos = 20
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_tvalid_i,
  output logic      s_tready_o,
  input  logic [39:0] s_tdata_i,  // reg_addr[7:0], servo_count[12:8], servo_id[20:13],
                                  // value[36:21], zero pad[39:37]
  input  logic [1:0] s_tuser_i,   // kind[1:0]
  output logic      push_o,
  output ssf_job_t  job_o,
  input  logic      full_i
);

  localparam logic [4:0] MaxCount = 5'(MaxServos);

  kind_e       active_kind_q, active_kind_d;
  logic [4:0]  entries_left_q, entries_left_d;
  kind_e       kind_in;
  logic [4:0]  count_in;
  logic [7:0]  count_ext;
  logic [7:0]  len;
  logic [7:0]  start_reg;
  logic        idle;
  logic        bad_count;
  logic        accept;

  // Field extraction and request acceptance.
  assign kind_in    = kind_e'(s_tuser_i);
  assign count_in   = s_tdata_i[12:8];
  assign count_ext  = {3'b000, count_in};
  assign idle       = (entries_left_q == 5'd0);
  assign bad_count  = (count_in == 5'd0) || (count_in > MaxCount);
  assign s_tready_o = !full_i;
  assign accept     = s_tvalid_i && !full_i;
  assign push_o     = accept && !(idle && bad_count);

  // Length byte and start register of a new packet, modulo 256.
  always_comb begin
    case (kind_in)
      KIND_READ_POS: begin
        len       = count_ext + 8'd4;
        start_reg = REG_PRESENT_POS;
      end
      KIND_WRITE_POS: begin
        len       = (count_ext << 2) + count_ext + 8'd4;
        start_reg = REG_GOAL_POS;
      end
      KIND_WRITE_SPEED: begin
        len       = (count_ext << 1) + count_ext + 8'd4;
        start_reg = REG_SPEED;
      end
      default: begin
        len       = (count_ext << 1) + 8'd4;
        start_reg = s_tdata_i[7:0];
      end
    endcase
  end

  // Job handed to the sequencer.
  always_comb begin
    job_o.first     = idle;
    job_o.last      = idle ? (count_in == 5'd1) : (entries_left_q == 5'd1);
    job_o.kind      = idle ? kind_in : active_kind_q;
    job_o.start_reg = start_reg;
    job_o.len       = len;
    job_o.id        = s_tdata_i[20:13];
    job_o.value     = s_tdata_i[36:21];
  end

  // Packet tracking: a new packet samples kind and count, later entries count down.
  always_comb begin
    active_kind_d  = active_kind_q;
    entries_left_d = entries_left_q;
    if (push_o) begin
      if (idle) begin
        active_kind_d  = kind_in;
        entries_left_d = count_in - 5'd1;
      end else begin
        entries_left_d = entries_left_q - 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_kind_q  <= KIND_READ_POS;
      entries_left_q <= 5'd0;
    end else begin
      active_kind_q  <= active_kind_d;
      entries_left_q <= entries_left_d;
    end
  end

endmodule

// ===== design/ssf_queue.sv =====
// Short job queue that decouples the front end from the byte sequencer.
// Depends on ssf_pkg for the job type and the queue depth.
module ssf_queue
  import ssf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  ssf_job_t job_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     empty_o,
  output ssf_job_t head_o
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  ssf_job_t            slot_q [QUEUE_DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     fill_q, fill_d;
  logic                do_push;
  logic                do_pop;

  assign full_o  = (fill_q == CntW'(QUEUE_DEPTH));
  assign empty_o = (fill_q == '0);
  assign head_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and fill level update, wrapping at the queue depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   fill_d = fill_q + 1'b1;
      2'b01:   fill_d = fill_q - 1'b1;
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Job storage; contents need no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

// ===== design/ssf_back.sv =====
// Back end of the framer: serialises the job at the head of the queue into
// packet bytes, keeps the running checksum and drives the output register.
// Depends on ssf_pkg.
module ssf_back
  import ssf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  input  ssf_job_t   head_i,
  output logic       pop_o,
  output logic       m_tvalid_o,
  input  logic       m_tready_i,
  output logic [7:0] m_tdata_o,   // out_byte[7:0]
  output logic       m_tlast_o    // last_byte
);

  step_t       step_q, step_d;
  logic        started_q, started_d;
  logic [7:0]  sum_q, sum_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q;
  logic        out_last_q;
  step_t       cur_step;
  step_t       next_step;
  logic        data_last;
  logic        job_done;
  logic        emit;
  logic [7:0]  byte_val;
  logic [7:0]  dlen;

  // Current position: a fresh job starts at the header or at its id byte.
  assign cur_step = started_q ? step_q : (head_i.first ? STEP_SYNC0 : STEP_ID);
  assign emit     = !empty_i && (!out_valid_q || m_tready_i);

  // Data length per servo for the header.
  always_comb begin
    case (head_i.kind)
      KIND_READ_POS:    dlen = 8'd2;
      KIND_WRITE_POS:   dlen = 8'd4;
      KIND_WRITE_SPEED: dlen = 8'd2;
      default:          dlen = 8'd1;
    endcase
  end

  // Byte at the current position.
  always_comb begin
    case (cur_step)
      STEP_SYNC0: byte_val = SYNC_BYTE;
      STEP_SYNC1: byte_val = SYNC_BYTE;
      STEP_BCAST: byte_val = BCAST_ID;
      STEP_LEN:   byte_val = head_i.len;
      STEP_INST:  byte_val = (head_i.kind == KIND_READ_POS) ? INSTR_SYNC_RD
                                                           : INSTR_SYNC_WR;
      STEP_START: byte_val = head_i.start_reg;
      STEP_DLEN:  byte_val = dlen;
      STEP_ID:    byte_val = head_i.id;
      STEP_DATA0: byte_val = head_i.value[7:0];
      STEP_DATA1: byte_val = head_i.value[15:8];
      STEP_DATA2: byte_val = 8'h00;
      STEP_DATA3: byte_val = 8'h00;
      STEP_CSUM:  byte_val = ~sum_q;
      default:    byte_val = 8'h00;
    endcase
  end

  // Whether the current byte is the last of the entry's own bytes.
  always_comb begin
    case (cur_step)
      STEP_ID:    data_last = (head_i.kind == KIND_READ_POS);
      STEP_DATA0: data_last = (head_i.kind == KIND_WRITE_BYTE);
      STEP_DATA1: data_last = (head_i.kind == KIND_WRITE_SPEED);
      STEP_DATA3: data_last = 1'b1;
      default:    data_last = 1'b0;
    endcase
  end

  // Next position, and whether the job leaves the queue after this byte.
  always_comb begin
    job_done  = 1'b0;
    next_step = cur_step + 4'd1;
    if (cur_step == STEP_CSUM) begin
      job_done = 1'b1;
    end else if (data_last) begin
      job_done  = !head_i.last;
      next_step = STEP_CSUM;
    end
  end

  assign pop_o = emit && job_done;

  // Sequencer and checksum update; the sum restarts at the broadcast id.
  always_comb begin
    step_d      = step_q;
    started_d   = started_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q && !m_tready_i;
    if (emit) begin
      out_valid_d = 1'b1;
      started_d   = !job_done;
      step_d      = next_step;
      case (cur_step)
        STEP_SYNC0: sum_d = sum_q;
        STEP_SYNC1: sum_d = sum_q;
        STEP_BCAST: sum_d = BCAST_ID;
        STEP_CSUM:  sum_d = 8'h00;
        default:    sum_d = sum_q + byte_val;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_SYNC0;
      started_q   <= 1'b0;
      sum_q       <= 8'h00;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      started_q   <= started_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= byte_val;
      out_last_q <= (cur_step == STEP_CSUM);
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_byte_q;
  assign m_tlast_o  = out_last_q;

endmodule

// ===== design/servo_sync_packet_framer_top.sv =====
// Servo sync packet framer: one servo entry in, the packet bytes it adds out.
// The first byte of an entry passes through the job queue and the output register.
// Throughput: one byte per cycle while m_axis_tready is high; an entry adds 1 to 13 bytes
// (5 for a mid-packet position write); a four-deep job queue lets entries arrive meanwhile.
// Reset (rst_ni, asynchronous, active low) returns to idle between packets and
// empties the queue.
module servo_sync_packet_framer_top
  import ssf_pkg::*;
#(
  parameter int MAX_SERVOS = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // reg_addr[7:0], servo_count[12:8], servo_id[20:13],
                                      // value[36:21], zero pad[39:37]
  input  logic [1:0]  s_axis_tuser,   // kind[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_byte[7:0]
  output logic        m_axis_tlast    // last_byte
);

  ssf_job_t push_job;
  ssf_job_t head_job;
  logic     push;
  logic     full;
  logic     pop;
  logic     empty;

  // Classifier and packet tracker.
  ssf_front #(
    .MaxServos (MAX_SERVOS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .push_o     (push),
    .job_o      (push_job),
    .full_i     (full)
  );

  // Job queue between the two halves.
  ssf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head_job)
  );

  // Byte sequencer and output register.
  ssf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .head_i     (head_job),
    .pop_o      (pop),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tlast_o  (m_axis_tlast)
  );

endmodule

// ===== design/ssf_checker.sv =====
// Port-level checker for the servo sync packet framer, bound to the top level.
// Depends on assert_macros.svh for the assertion macros.
`include "assert_macros.svh"

module ssf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_tvalid_i,
  input logic       m_tready_i,
  input logic [7:0] m_tdata_i,
  input logic       m_tlast_i
);

  logic [1:0] pos_q;
  logic [7:0] sum_q;
  logic       out_req;

  assign out_req = m_tvalid_i && m_tready_i;

  // Position within the packet (saturating after the header prefix) and the
  // sum of the bytes from the broadcast id onwards.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 2'd0;
      sum_q <= 8'h00;
    end else if (out_req) begin
      if (m_tlast_i) begin
        pos_q <= 2'd0;
        sum_q <= 8'h00;
      end else begin
        pos_q <= (pos_q == 2'd3) ? pos_q : pos_q + 2'd1;
        sum_q <= (pos_q >= 2'd2) ? sum_q + m_tdata_i : sum_q;
      end
    end
  end

  // A stalled output byte stays offered and unchanged.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_tvalid_i && !m_tready_i, m_tvalid_i && $stable(m_tdata_i) && $stable(m_tlast_i), "output changed while stalled")

  // Every packet opens with the two sync bytes.
  `ASSERT_IMPL(a_sync, clk_i, rst_ni, out_req && (pos_q == 2'd0 || pos_q == 2'd1), m_tdata_i == 8'hFF && !m_tlast_i, "packet does not open with sync bytes")

  // The broadcast id follows the sync bytes.
  `ASSERT_IMPL(a_bcast, clk_i, rst_ni, out_req && pos_q == 2'd2, m_tdata_i == 8'hFE && !m_tlast_i, "broadcast id missing")

  // The closing byte is the inverted sum of the bytes from the broadcast id on.
  `ASSERT_IMPL(a_csum, clk_i, rst_ni, out_req && m_tlast_i, m_tdata_i == ~sum_q, "checksum mismatch")

endmodule

bind servo_sync_packet_framer_top ssf_checker u_ssf_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .m_tvalid_i (m_axis_tvalid),
  .m_tready_i (m_axis_tready),
  .m_tdata_i  (m_axis_tdata),
  .m_tlast_i  (m_axis_tlast)
);
